// ===== hdl/per_address_byte_accumulator_assert.svh =====
// Assertion macros for the per-address byte accumulator checker.
// Depends on nothing; included by the checker file.
`ifndef PER_ADDRESS_BYTE_ACCUMULATOR_ASSERT_SVH
`define PER_ADDRESS_BYTE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define PAB_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pab assertion failed");

// Next-cycle implication under a synchronous reset.
`define PAB_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pab assertion failed");

`endif

// ===== hdl/pab_pkg.sv =====
// Shared constants, codes and types of the per-address byte accumulator.
// Depends on nothing; used by every other file of the block but pab_ram and the assertion header.
`default_nettype none

package pab_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = 7;
  localparam int ADDR_W        = 48;
  localparam int KEY_W         = 48;
  localparam int PREFIX_W      = 24;
  localparam int TOT_W         = 32;
  localparam int LEN_W         = 16;
  localparam int REG_IDX_W     = 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [REG_IDX_W-1:0] REG_USE_RECEIVER = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_PREFIX_ONLY  = 1'b1;

  typedef enum logic [0:0] {
    OP_ACCUMULATE = 1'b0,
    OP_READOUT    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_NEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_READ  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t           op;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  key;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/pab_if.sv =====
// Valid/ready channel interfaces for packet records and table results.
// Depends on pab_pkg for field widths and codes.
`default_nettype none

interface pab_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [pab_pkg::ADDR_W-1:0]   tx_address;
  logic [pab_pkg::ADDR_W-1:0]   rx_address;
  logic [pab_pkg::LEN_W-1:0]    packet_length;

  modport source (output valid, opcode, tx_address, rx_address, packet_length,
                  input ready);
  modport sink   (input valid, opcode, tx_address, rx_address, packet_length,
                  output ready);
endinterface

interface pab_out_if;
  logic                         valid;
  logic                         ready;
  pab_pkg::status_t             status;
  logic [pab_pkg::KEY_W-1:0]    entry_key;
  logic [pab_pkg::TOT_W-1:0]    entry_total;
  logic [pab_pkg::CNT_W-1:0]    entry_count;
  logic                         is_last;

  modport source (output valid, status, entry_key, entry_total, entry_count, is_last,
                  input ready);
  modport sink   (input valid, status, entry_key, entry_total, entry_count, is_last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/per_address_byte_accumulator.sv =====
// Per-address byte accumulator: front end, command queue and table engine.
// A readout of n entries gives one result per cycle while the result channel is ready.
// The next record waits until the table engine is idle; up to two more are queued.
// Synchronous active-high reset empties the table and clears both select registers.
// Depends on pab_pkg, pab_if, pab_front, pab_queue and pab_back.
`default_nettype none

module per_address_byte_accumulator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pab_in_if.sink                              pkt,
  pab_out_if.source                           res,
  input  wire logic                           wr_en,
  input  wire logic [pab_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic                           wr_data
);
  import pab_pkg::*;

  logic  front_valid;
  cmd_t  front_cmd;
  logic  front_ready;
  logic  back_valid;
  cmd_t  back_cmd;
  logic  back_ready;

  pab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  pab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_cmd   (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_cmd    (back_cmd),
    .pop_ready  (back_ready)
  );

  pab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_ready (back_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

// ===== hdl/pab_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read.
// Depends on nothing.
`default_nettype none

module pab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pab_front.sv =====
// Front end: holds the key-selection registers and turns packet records into commands.
// Depends on pab_pkg and pab_in_if.
`default_nettype none

module pab_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pab_in_if.sink                              pkt,
  input  wire logic                           wr_en,
  input  wire logic [pab_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic                           wr_data,
  output logic                                cmd_valid,
  output pab_pkg::cmd_t                       cmd,
  input  wire logic                           cmd_ready
);
  import pab_pkg::*;

  logic              use_receiver;
  logic              prefix_only;
  logic [ADDR_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_receiver <= 1'b0;
      prefix_only  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_USE_RECEIVER: use_receiver <= wr_data;
        REG_PREFIX_ONLY:  prefix_only  <= wr_data;
        default: ;
      endcase
    end
  end

  assign addr      = use_receiver ? pkt.rx_address : pkt.tx_address;
  assign cmd_valid = pkt.valid;
  assign pkt.ready = cmd_ready;

  always_comb begin
    cmd.op  = opcode_t'(pkt.opcode);
    cmd.len = pkt.packet_length;
    if (prefix_only) begin
      cmd.key = {{(KEY_W-PREFIX_W){1'b0}}, addr[ADDR_W-1 -: PREFIX_W]};
    end else begin
      cmd.key = addr;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pab_queue.sv =====
// Short command queue that decouples the front end from the table engine.
// Depends on pab_pkg.
`default_nettype none

module pab_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire pab_pkg::cmd_t push_cmd,
  output logic               push_ready,
  output logic               pop_valid,
  output pab_pkg::cmd_t      pop_cmd,
  input  wire logic          pop_ready
);
  import pab_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slot[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pab_back.sv =====
// Table engine: scans the key memory, updates totals, appends entries and reads out.
// Depends on pab_pkg, pab_out_if and pab_ram.
`default_nettype none

module pab_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire pab_pkg::cmd_t  cmd,
  output logic                cmd_ready,
  pab_out_if.source           res
);
  import pab_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_MISS,
    S_EMPTY,
    S_READ
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [KEY_W-1:0]  key;
  logic [LEN_W-1:0]  len;
  logic [TOT_W-1:0]  hit_total;
  logic              out_valid;
  result_t           out;

  logic                   take;
  logic                   can_load;
  logic                   load;
  logic                   at_end;
  logic                   match;
  logic                   has_room;
  logic [TOT_W:0]         sum;
  logic [TOT_W-1:0]       sat;
  logic [KEY_W-1:0]       rd_key;
  logic [TOT_W-1:0]       rd_total;
  logic [KEY_W+TOT_W-1:0] rd_data;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [KEY_W+TOT_W-1:0] ram_wdata;

  pab_ram #(
    .WIDTH (KEY_W + TOT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign rd_key    = rd_data[KEY_W+TOT_W-1 -: KEY_W];
  assign rd_total  = rd_data[TOT_W-1:0];
  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign can_load  = !out_valid || res.ready;
  assign load      = can_load && (state inside {S_ADD, S_MISS, S_EMPTY, S_READ});
  assign at_end    = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign match     = (rd_key == key);
  assign has_room  = (count < CNT_W'(TABLE_ENTRIES));
  assign sum       = {1'b0, hit_total} + (TOT_W+1)'(len);
  assign sat       = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx + IDX_W'(1);
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {key, sat};
    case (state)
      S_IDLE: begin
        if (take && count != '0) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_SCAN: ram_re = !match && !at_end;
      S_READ: ram_re = can_load && !at_end;
      S_ADD:  ram_we = can_load;
      S_MISS: begin
        ram_we    = can_load && has_room;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = {key, TOT_W'(len)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            key <= cmd.key;
            len <= cmd.len;
            idx <= '0;
            if (cmd.op == OP_READOUT) begin
              state <= (count == '0) ? S_EMPTY : S_READ;
            end else begin
              state <= (count == '0) ? S_MISS : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_total <= rd_total;
            state     <= S_ADD;
          end else if (at_end) begin
            state <= S_MISS;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_ADD: begin
          if (can_load) begin
            out.status <= ST_ADDED;
            out.key    <= key;
            out.total  <= sat;
            out.count  <= count;
            out.last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_MISS: begin
          if (can_load) begin
            out.key   <= key;
            out.last  <= 1'b1;
            if (has_room) begin
              out.status <= ST_NEW;
              out.total  <= TOT_W'(len);
              out.count  <= count + CNT_W'(1);
              count      <= count + CNT_W'(1);
            end else begin
              out.status <= ST_FULL;
              out.total  <= '0;
              out.count  <= count;
            end
            state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (can_load) begin
            out.status <= ST_EMPTY;
            out.key    <= '0;
            out.total  <= '0;
            out.count  <= '0;
            out.last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          if (can_load) begin
            out.status <= ST_READ;
            out.key    <= rd_key;
            out.total  <= rd_total;
            out.count  <= count;
            out.last   <= at_end;
            if (at_end) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out.status;
  assign res.entry_key   = out.key;
  assign res.entry_total = out.total;
  assign res.entry_count = out.count;
  assign res.is_last     = out.last;

endmodule

`default_nettype wire

// ===== hdl/pab_checker.sv =====
// Port-level checks on the result channel of the per-address byte accumulator.
// Depends on pab_pkg and per_address_byte_accumulator_assert.svh; bound to the top level.
`default_nettype none
`include "per_address_byte_accumulator_assert.svh"

module pab_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        res_valid,
  input  wire logic                        res_ready,
  input  wire pab_pkg::status_t            status,
  input  wire logic [pab_pkg::KEY_W-1:0]   entry_key,
  input  wire logic [pab_pkg::TOT_W-1:0]   entry_total,
  input  wire logic [pab_pkg::CNT_W-1:0]   entry_count,
  input  wire logic                        is_last
);
  import pab_pkg::*;

  logic single_result;
  logic empty_ok;
  logic full_ok;

  assign single_result = (status == ST_ADDED) || (status == ST_NEW) || (status == ST_FULL);
  assign empty_ok = (entry_count == '0) && (entry_key == '0) && (entry_total == '0) && is_last;
  assign full_ok  = (entry_count == CNT_W'(TABLE_ENTRIES)) && (entry_total == '0);

  `PAB_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `PAB_ASSERT_IMP(a_single_last, clk, rst, res_valid && single_result, is_last)
  `PAB_ASSERT_IMP(a_empty_form, clk, rst, res_valid && status == ST_EMPTY, empty_ok)
  `PAB_ASSERT_IMP(a_full_form, clk, rst, res_valid && status == ST_FULL, full_ok)

endmodule

bind per_address_byte_accumulator pab_checker u_pab_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .status      (res.status),
  .entry_key   (res.entry_key),
  .entry_total (res.entry_total),
  .entry_count (res.entry_count),
  .is_last     (res.is_last)
);

`default_nettype wire
